// ===== src/rpc_pkg.sv =====
// shared types, constants and arctangent table for the rectangular/polar converter
`timescale 1ns / 1ps
`default_nettype none
package rpc_pkg;

  localparam int DATA_WIDTH  = 24;
  localparam int ANGLE_WIDTH = 16;
  localparam int STAGES      = 16;

  localparam int GUARD      = 8;
  localparam int ZW         = 32;
  localparam int TABLE_LEN  = 24;
  localparam int NCELLS     = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
  localparam int TAB_IDX_W  = $clog2(TABLE_LEN);
  localparam int CW         = DATA_WIDTH + GUARD + 4;
  localparam int MAGW       = DATA_WIDTH - 1;
  localparam int SPLIT      = 20;
  localparam int HIW        = CW - SPLIT;

  localparam logic [31:0] KGAIN = 32'd2608131496;

  localparam logic [1:0] FORM_RECT  = 2'd0;
  localparam logic [1:0] FORM_POLAR = 2'd1;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [DATA_WIDTH-1:0] first_operand;
    logic signed [DATA_WIDTH-1:0] second_operand;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  x_out;
    logic signed [DATA_WIDTH-1:0]  y_out;
    logic [DATA_WIDTH-1:0]         magnitude_out;
    logic signed [ANGLE_WIDTH-1:0] angle_out;
    logic                          bad_form;
  } res_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [DATA_WIDTH-1:0] opa;
    logic signed [DATA_WIDTH-1:0] opb;
    logic signed [CW-1:0]         x;
    logic signed [CW-1:0]         y;
    logic [ZW-1:0]                z;
  } cord_t;

  function automatic logic [ZW-1:0] atan_val(input logic [TAB_IDX_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/rect_polar_converter_top.sv =====
// top level: input stage, chain of cordic cells and output stages
`timescale 1ns / 1ps
`default_nettype none
// Converts one transaction per clock, while res_ready is high, between
// rectangular (x, y) and polar (magnitude, binary angle) form with a fully
// pipelined cordic: one input stage, one registered cell per micro-rotation,
// two output stages for gain removal and
// rounding. Every stage holds one transaction and has its own valid bit, so
// when res_ready is low the chain keeps filling until each stage is occupied;
// cmd_ready drops only once the whole chain is full.
module rect_polar_converter_top
  import rpc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  cord_t chain       [NCELLS+1];
  logic  chain_valid [NCELLS+1];
  logic  chain_ready [NCELLS+1];
  logic  all_full;

  rpc_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cmd_valid),
    .up_ready (cmd_ready),
    .up       (cmd),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn       (chain[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    rpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (TAB_IDX_W'(g)),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up       (chain[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn       (chain[g+1])
    );
  end

  rpc_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[NCELLS]),
    .up_ready (chain_ready[NCELLS]),
    .up       (chain[NCELLS]),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn       (res)
  );

  always_comb begin
    all_full = 1'b1;
    for (int i = 0; i <= NCELLS; i++) begin
      all_full = all_full && chain_valid[i];
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bad_form |-> res.x_out == '0 && res.y_out == '0 &&
      res.magnitude_out == '0 && res.angle_out == '0)
    else $error("invalid form result carries nonzero fields");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> all_full && res_valid && !res_ready)
    else $error("input stalled while the chain has a free stage");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    res_ready && !chain_valid[NCELLS] |=> !chain_valid[NCELLS] || $past(chain_valid[NCELLS-1]))
    else $error("cell output appeared without an upstream transaction");

endmodule
`default_nettype wire

// ===== src/rpc_pre.sv =====
// input stage: quadrant fold, gain prescale for polar form, cordic start values
`timescale 1ns / 1ps
`default_nettype none
module rpc_pre
  import rpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire cmd_t  up,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output cord_t      dn
);

  localparam int PW = MAGW + 32;

  logic                 vld;
  cord_t                nxt;
  logic [MAGW-1:0]      mag;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        prod_r;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] xp;
  logic [ZW-1:0]        zp;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;

  always_comb begin
    mag    = up.first_operand[DATA_WIDTH-1] ? '0 : up.first_operand[MAGW-1:0];
    prod   = PW'(mag) * PW'(KGAIN);
    prod_r = prod + (PW'(1) << (31 - GUARD));
    xp     = {{(CW - (PW - 32 + GUARD)){1'b0}}, prod_r[PW-1:32-GUARD]};
    zp     = {up.second_operand[ANGLE_WIDTH-1:0], {(ZW-ANGLE_WIDTH){1'b0}}};
    xr     = {{(CW-DATA_WIDTH-GUARD){up.first_operand[DATA_WIDTH-1]}},
              up.first_operand, {GUARD{1'b0}}};
    nxt.func = up.func;
    nxt.opb  = up.second_operand;
    if (up.func == FORM_RECT) begin
      nxt.opa = up.first_operand;
      if (up.first_operand[DATA_WIDTH-1]) begin
        nxt.x = -xr;
        nxt.y = -{{(CW-DATA_WIDTH-GUARD){up.second_operand[DATA_WIDTH-1]}},
                  up.second_operand, {GUARD{1'b0}}};
        nxt.z = 32'h80000000;
      end else begin
        nxt.x = xr;
        nxt.y = {{(CW-DATA_WIDTH-GUARD){up.second_operand[DATA_WIDTH-1]}},
                 up.second_operand, {GUARD{1'b0}}};
        nxt.z = '0;
      end
    end else begin
      nxt.opa = {1'b0, mag};
      nxt.y   = '0;
      // left half: rotate by pi first
      if (zp[31] ^ zp[30]) begin
        nxt.x = -xp;
        nxt.z = {~zp[31], zp[30:0]};
      end else begin
        nxt.x = xp;
        nxt.z = zp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rpc_cell.sv =====
// one cordic micro-rotation cell with its own pipeline register
`timescale 1ns / 1ps
`default_nettype none
module rpc_cell
  import rpc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [TAB_IDX_W-1:0] idx,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire cord_t                up,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output cord_t                     dn
);

  logic                 vld;
  cord_t                nxt;
  logic signed [CW-1:0] xi;
  logic signed [CW-1:0] yi;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [ZW-1:0]        atn;
  logic                 pos;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;

  always_comb begin
    xi  = up.x;
    yi  = up.y;
    xs  = xi >>> idx;
    ys  = yi >>> idx;
    atn = atan_val(idx);
    nxt = up;
    // vectoring drives y to zero, rotation drives z to zero
    if (up.func == FORM_RECT) begin
      pos = !yi[CW-1];
      if (pos) begin
        nxt.x = xi + ys;
        nxt.y = yi - xs;
        nxt.z = up.z + atn;
      end else begin
        nxt.x = xi - ys;
        nxt.y = yi + xs;
        nxt.z = up.z - atn;
      end
    end else begin
      pos = !up.z[ZW-1];
      if (pos) begin
        nxt.x = xi - ys;
        nxt.y = yi + xs;
        nxt.z = up.z - atn;
      end else begin
        nxt.x = xi + ys;
        nxt.y = yi - xs;
        nxt.z = up.z + atn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/rpc_post.sv =====
// output stages: gain removal, rounding, saturation and result formatting
`timescale 1ns / 1ps
`default_nettype none
module rpc_post
  import rpc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire cord_t up,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output res_t       dn
);

  localparam int SW   = CW + 32;
  localparam int MFW  = SW - 32 - GUARD;

  typedef struct packed {
    logic [1:0]                    func;
    logic signed [DATA_WIDTH-1:0]  opa;
    logic signed [DATA_WIDTH-1:0]  opb;
    logic [HIW+31:0]               p_hi;
    logic [SPLIT+31:0]             p_lo;
    logic signed [DATA_WIDTH-1:0]  xr;
    logic signed [DATA_WIDTH-1:0]  yr;
    logic [ANGLE_WIDTH-1:0]        ang;
    logic                          origin;
  } mid_t;

  logic                 a_vld;
  logic                 a_ready;
  mid_t                 a;
  mid_t                 a_nxt;
  logic                 b_vld;
  res_t                 b_nxt;
  logic signed [CW-1:0] xt;
  logic signed [CW-1:0] yt;
  logic [ZW-1:0]        zr;
  logic [SW-1:0]        sum;
  logic [MFW-1:0]       mfull;

  function automatic logic signed [DATA_WIDTH-1:0] sat_s(input logic signed [CW-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if ((&v[CW-1:DATA_WIDTH-1]) || !(|v[CW-1:DATA_WIDTH-1])) begin
      r = v[DATA_WIDTH-1:0];
    end else if (v[CW-1]) begin
      r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  assign up_ready = !a_vld || a_ready;
  assign a_ready  = !b_vld || dn_ready;
  assign dn_valid = b_vld;

  always_comb begin
    xt = (up.x + (CW'(1) << (GUARD - 1))) >>> GUARD;
    yt = (up.y + (CW'(1) << (GUARD - 1))) >>> GUARD;
    zr = up.z + (ZW'(1) << (31 - ANGLE_WIDTH));
    a_nxt.func   = up.func;
    a_nxt.opa    = up.opa;
    a_nxt.opb    = up.opb;
    a_nxt.p_hi   = (HIW+32)'(up.x[CW-1:SPLIT]) * (HIW+32)'(KGAIN);
    a_nxt.p_lo   = (SPLIT+32)'(up.x[SPLIT-1:0]) * (SPLIT+32)'(KGAIN);
    a_nxt.xr     = sat_s(xt);
    a_nxt.yr     = sat_s(yt);
    a_nxt.ang    = zr[ZW-1:ZW-ANGLE_WIDTH];
    a_nxt.origin = (up.opa == '0) && (up.opb == '0);
  end

  always_comb begin
    sum   = {a.p_hi, {SPLIT{1'b0}}} + SW'(a.p_lo) + (SW'(1) << (31 + GUARD));
    mfull = sum[SW-1:32+GUARD];
    b_nxt = '0;
    case (a.func)
      FORM_RECT: begin
        b_nxt.x_out = a.opa;
        b_nxt.y_out = a.opb;
        if (!a.origin) begin
          b_nxt.magnitude_out = (|mfull[MFW-1:DATA_WIDTH]) ? '1 : mfull[DATA_WIDTH-1:0];
          b_nxt.angle_out     = a.ang;
        end
      end
      FORM_POLAR: begin
        b_nxt.x_out         = a.xr;
        b_nxt.y_out         = a.yr;
        b_nxt.magnitude_out = a.opa;
        b_nxt.angle_out     = a.opb[ANGLE_WIDTH-1:0];
      end
      default: begin
        b_nxt.bad_form = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (up_ready) begin
        a_vld <= up_valid;
      end
      if (a_ready) begin
        b_vld <= a_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      a <= a_nxt;
    end
    if (a_vld && a_ready) begin
      dn <= b_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the rectangular/polar cordic converter
`timescale 1ns / 1ps
module testbench;
  import rpc_pkg::*;

  localparam logic [1:0] FORM_BAD2 = 2'd2;
  localparam logic [1:0] FORM_BAD3 = 2'd3;
  localparam int TAB_SIZE = 24;
  localparam logic [31:0] ARC_LUT [TAB_SIZE] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };
  localparam longint SMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint unsigned UMAX = (64'd1 << DATA_WIDTH) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  res_t pending_res[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  rect_polar_converter_top dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // round-half-up of v * gain / 2^s
  function automatic longint unsigned gain_round(input longint unsigned v, input int s);
    logic [127:0] p;
    p = 128'(v) * 128'(KGAIN);
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic longint clip_signed(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic res_t predict_conversion(input cmd_t c);
    res_t r;
    longint a, b, px, py, nx;
    longint unsigned mag;
    logic [31:0] z;
    r = '0;
    a = $signed(c.first_operand);
    b = $signed(c.second_operand);
    if (c.func == FORM_RECT) begin
      r.x_out = c.first_operand;
      r.y_out = c.second_operand;
      if (a != 0 || b != 0) begin
        px = a * (longint'(1) <<< GUARD);
        py = b * (longint'(1) <<< GUARD);
        z = '0;
        if (px < 0) begin
          px = -px;
          py = -py;
          z = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES && i < TAB_SIZE; i++) begin
          if (py >= 0) begin
            nx = px + (py >>> i);
            py = py - (px >>> i);
            z = z + ARC_LUT[i];
          end else begin
            nx = px - (py >>> i);
            py = py + (px >>> i);
            z = z - ARC_LUT[i];
          end
          px = nx;
        end
        mag = gain_round(longint'(px), 32 + GUARD);
        if (mag > UMAX) mag = UMAX;
        r.magnitude_out = mag[DATA_WIDTH-1:0];
        z = z + (32'd1 << (31 - ANGLE_WIDTH));
        r.angle_out = z[31 -: ANGLE_WIDTH];
      end
    end else if (c.func == FORM_POLAR) begin
      mag = (a < 0) ? 64'd0 : 64'(a);
      z = {c.second_operand[ANGLE_WIDTH-1:0], {(32 - ANGLE_WIDTH){1'b0}}};
      px = longint'(gain_round(mag << GUARD, 32));
      py = 0;
      if (z >= 32'h4000_0000 && z < 32'hC000_0000) begin
        z = z - 32'h8000_0000;
        px = -px;
      end
      for (int i = 0; i < STAGES && i < TAB_SIZE; i++) begin
        if (!z[31]) begin
          nx = px - (py >>> i);
          py = py + (px >>> i);
          z = z - ARC_LUT[i];
        end else begin
          nx = px + (py >>> i);
          py = py - (px >>> i);
          z = z + ARC_LUT[i];
        end
        px = nx;
      end
      px = clip_signed((px + (longint'(1) <<< (GUARD - 1))) >>> GUARD);
      py = clip_signed((py + (longint'(1) <<< (GUARD - 1))) >>> GUARD);
      r.x_out = px[DATA_WIDTH-1:0];
      r.y_out = py[DATA_WIDTH-1:0];
      r.magnitude_out = mag[DATA_WIDTH-1:0];
      r.angle_out = c.second_operand[ANGLE_WIDTH-1:0];
    end else begin
      r.bad_form = 1'b1;
    end
    return r;
  endfunction

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_valid && res_ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected transaction on result channel");
        errors++;
      end else begin
        exp_r = pending_res.pop_front();
        if (res.x_out !== exp_r.x_out) begin
          $error("x_out: expected %0d actual %0d", exp_r.x_out, res.x_out);
          errors++;
        end
        if (res.y_out !== exp_r.y_out) begin
          $error("y_out: expected %0d actual %0d", exp_r.y_out, res.y_out);
          errors++;
        end
        if (res.magnitude_out !== exp_r.magnitude_out) begin
          $error("magnitude_out: expected %0d actual %0d", exp_r.magnitude_out,
                 res.magnitude_out);
          errors++;
        end
        if (res.angle_out !== exp_r.angle_out) begin
          $error("angle_out: expected %0d actual %0d", exp_r.angle_out, res.angle_out);
          errors++;
        end
        if (res.bad_form !== exp_r.bad_form) begin
          $error("bad_form: expected %0b actual %0b", exp_r.bad_form, res.bad_form);
          errors++;
        end
      end
    end
  end

  task automatic send_cmd(input logic [1:0] f, input logic signed [DATA_WIDTH-1:0] op1,
                          input logic signed [DATA_WIDTH-1:0] op2);
    cmd_t c;
    c.func = f;
    c.first_operand = op1;
    c.second_operand = op2;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    pending_res.push_back(predict_conversion(c));
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] rand_operand();
    int k;
    k = $urandom_range(7);
    if (k < 4) return DATA_WIDTH'($urandom);
    if (k < 7) return DATA_WIDTH'(int'($urandom_range(16383)) - 8192);
    case ($urandom_range(4))
      0: return '0;
      1: return DATA_WIDTH'(1);
      2: return '1;
      3: return DATA_WIDTH'(SMAX);
      default: return DATA_WIDTH'(SMIN);
    endcase
  endfunction

  task automatic test_rect_directed();
    logic signed [DATA_WIDTH-1:0] mx, mn;
    mx = DATA_WIDTH'(SMAX);
    mn = DATA_WIDTH'(SMIN);
    send_cmd(FORM_RECT, 0, 0);
    send_cmd(FORM_RECT, mx, 0);
    send_cmd(FORM_RECT, mn, 0);
    send_cmd(FORM_RECT, 0, mx);
    send_cmd(FORM_RECT, 0, mn);
    send_cmd(FORM_RECT, mx, mx);
    send_cmd(FORM_RECT, mn, mn);
    send_cmd(FORM_RECT, mx, mn);
    send_cmd(FORM_RECT, mn, mx);
    send_cmd(FORM_RECT, -1, 1);
    send_cmd(FORM_RECT, 1, -1);
    send_cmd(FORM_RECT, -4096, 0);
  endtask

  task automatic test_polar_directed();
    send_cmd(FORM_POLAR, 4096, 0);
    send_cmd(FORM_POLAR, 4096, 24'h004000);
    send_cmd(FORM_POLAR, 4096, 24'h008000);
    send_cmd(FORM_POLAR, 4096, 24'h00C000);
    send_cmd(FORM_POLAR, 4096, 24'h003FFF);
    send_cmd(FORM_POLAR, 4096, 24'h00BFFF);
    send_cmd(FORM_POLAR, DATA_WIDTH'(SMAX), 0);
    send_cmd(FORM_POLAR, DATA_WIDTH'(SMAX), 24'h002000);
    send_cmd(FORM_POLAR, -5000, 24'h001234);
    send_cmd(FORM_POLAR, DATA_WIDTH'(SMIN), 24'h008000);
    send_cmd(FORM_POLAR, 1000, 24'hFF1234);
  endtask

  task automatic test_bad_form();
    send_cmd(FORM_BAD2, 24'h123456, 24'h654321);
    send_cmd(FORM_BAD3, DATA_WIDTH'(SMAX), DATA_WIDTH'(SMIN));
  endtask

  task automatic test_random_stream(input int n, input int s_pct, input int r_pct);
    int k;
    logic signed [DATA_WIDTH-1:0] op1;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(19);
      if (k < 9) begin
        send_cmd(FORM_RECT, rand_operand(), rand_operand());
      end else if (k < 18) begin
        if ($urandom_range(4) != 0) op1 = DATA_WIDTH'($urandom_range(int'(SMAX)));
        else op1 = rand_operand();
        send_cmd(FORM_POLAR, op1, DATA_WIDTH'($urandom));
      end else begin
        send_cmd(k[0] ? FORM_BAD3 : FORM_BAD2, rand_operand(), rand_operand());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 87;
    test_rect_directed();
    test_polar_directed();
    test_bad_form();
    test_random_stream(375, 12, 87);
    test_random_stream(375, 87, 12);
    test_random_stream(375, 0, 0);
    drain_results();
    if (errors == 0) begin
      $display("rect_polar_converter_top test passed");
    end else begin
      $display("rect_polar_converter_top test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("rect_polar_converter_top test failed");
    $finish;
  end

endmodule
